@@ design/mlc_pkg.sv @@
// ----------------------------------------------------------------------------
// mlc_pkg
// shared types and constants for the multiscale lattice complexity block
// ----------------------------------------------------------------------------
`default_nettype none

package mlc_pkg;

  localparam int MAX_SIDE  = 128;
  localparam int MAX_STEPS = 10;
  localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int DIVD_W    = 48;
  localparam int DIVS_W    = CNT_W;
  localparam int CPLX_W    = 40;

  localparam logic [CPLX_W-1:0] CPLX_MAX = {CPLX_W{1'b1}};

  localparam logic [1:0] CFG_LATTICE_SIDE = 2'd0;
  localparam logic [1:0] CFG_SCALE_BASE   = 2'd1;
  localparam logic [1:0] CFG_STEP_COUNT   = 2'd2;
  localparam logic [1:0] CFG_FIRST_SUMMED = 2'd3;

  typedef enum logic [4:0] {
    S_LOAD, S_CHK, S_CHKMUL, S_CHKMOD, S_CHKWAIT,
    S_STEP, S_STEP2, S_P1RD, S_P1ACC, S_AVGDIV, S_AVGWAIT,
    S_SQ, S_SQACC, S_P2RD, S_P2M1, S_P2M2, S_P2M3, S_NEXTBLK,
    S_OVLDIV, S_OVLWAIT, S_OVLACC, S_DONE, S_ERR
  } state_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quo;
    logic [DIVS_W-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

@@ design/mlc_ram.sv @@
// ----------------------------------------------------------------------------
// mlc_ram
// single-port-write, single-port-read synchronous memory, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module mlc_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 16384,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/mlc_div.sv @@
// ----------------------------------------------------------------------------
// mlc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mlc_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [mlc_pkg::DIVD_W-1:0] dividend,
  input  wire logic [mlc_pkg::DIVS_W-1:0] divisor,
  output mlc_pkg::div_res_t             res
);
  import mlc_pkg::*;

  localparam int CW = $clog2(DIVD_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dsr_r, dsr_nxt;
  logic [DIVS_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, quo_r[DIVD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DIVD_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIVS_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = DIVS_W'(trial);
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

`ifndef SYNTHESIS
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_busy_counts: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("divider count ran out while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && !start |=> !done_r) else $error("divider done held");
`endif

endmodule

`default_nettype wire

@@ design/multiscale_lattice_complexity.sv @@
// ----------------------------------------------------------------------------
// multiscale_lattice_complexity
// loads an n by n lattice, coarse-grains it over several scales and reports
// the summed absolute overlap between successive scales
// ----------------------------------------------------------------------------
// Usage: samples arrive on in_* in row order, one request per cycle while
// in_tready is high. The n*n-th sample closes the frame; the block then
// checks the configuration and walks the stored lattice twice per scale and
// finally delivers one request on out_* (complexity in tdata, error in tuser).
// Each scale reads every site twice through the memory read ports, once to
// sum its block and once for the overlap terms, and uses the shared
// multiplier and the divider: one averaging divide per block and one overlap
// divide per scale. An unusable configuration gives an error result. While
// the result waits on a stalled receiver, the next frame loads, but its last
// sample is held off until the result is taken.
// Reset empties the frame counter, restores the register defaults and drops
// out_tvalid; memory contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module multiscale_lattice_complexity (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] spin_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [39:0] complexity
  output logic      [0:0]  out_tuser,  // [0] config_error
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import mlc_pkg::*;

  state_t state_r, state_nxt;

  logic [7:0]        lside_r, base_r;
  logic [3:0]        steps_r, first_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [3:0]        k_r, k_nxt;
  logic [7:0]        lam_r, lam_nxt;
  logic [CNT_W-1:0]  area_r, area_nxt, stride_r, stride_nxt, side_r, side_nxt;
  logic [7:0]        r0_r, r0_nxt, c0_r, c0_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [ADDR_W-1:0] blk_r, blk_nxt, row_r, row_nxt;
  logic signed [47:0] sum_r, sum_nxt;
  logic signed [31:0] avg_r, avg_nxt;
  logic signed [63:0] sqf_r, sqf_nxt, s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [CPLX_W-1:0] acc_r, acc_nxt;
  logic              ov_r, ov_nxt;
  logic [CPLX_W-1:0] ocplx_r, ocplx_nxt;
  logic              oerr_r, oerr_nxt;

  logic              nvalid, load_last, last_site, chk_bad;
  logic [15:0]       nn_full;
  logic [CNT_W-1:0]  nn, limit;
  logic [CNT_W:0]    cnt_inc;
  logic [ADDR_W-1:0] addr;
  logic              rd_en, coarse_we;
  logic [15:0]       site_rd;
  logic [31:0]       coarse_rd;
  logic signed [31:0] prev;
  logic [22:0]       side_mul;
  logic [15:0]       lam_mul, area_mul, stride_mul;
  logic [8:0]        c0_end, r0_end;
  logic signed [65:0] t_full, t_mag;
  logic [47:0]       sum_mag;
  logic [48:0]       acc_sum;
  logic              div_start;
  logic [DIVD_W-1:0] div_dvd;
  logic [DIVS_W-1:0] div_dsr;
  div_res_t          div_res;

  // frame length
  assign nvalid    = (lside_r != 8'd0) && (lside_r <= 8'(MAX_SIDE));
  assign nn_full   = 16'(lside_r) * 16'(lside_r);
  assign nn        = nn_full[CNT_W-1:0];
  assign limit     = nvalid ? nn : CNT_W'(DEPTH);
  assign cnt_inc   = (CNT_W+1)'(cnt_r) + 1'b1;
  assign load_last = cnt_inc >= (CNT_W+1)'(limit);
  assign in_tready = (state_r == S_LOAD) && (!ov_r || !load_last);

  assign chk_bad = !nvalid || (base_r < 8'd2) || (steps_r == 4'd0) ||
                   (steps_r > 4'(MAX_STEPS));
  assign side_mul   = 23'(side_r) * 23'(base_r);
  assign lam_mul    = 16'(lam_r) * 16'(base_r);
  assign area_mul   = 16'(lam_r) * 16'(lam_r);
  assign stride_mul = 16'(lam_r) * 16'(lside_r);
  assign c0_end     = 9'(c0_r) + 9'(lam_r);
  assign r0_end     = 9'(r0_r) + 9'(lam_r);
  assign last_site  = (i_r == lam_r - 8'd1) && (j_r == lam_r - 8'd1);

  assign addr      = ADDR_W'(row_r + ADDR_W'(c0_r) + ADDR_W'(j_r));
  assign rd_en     = (state_r == S_P1RD) || (state_r == S_P2RD);
  assign coarse_we = (state_r == S_P2M3);
  assign prev      = (k_r == 4'd0) ? $signed({site_rd, 16'b0}) : $signed(coarse_rd);

  assign t_full  = (66'(s2_r) <<< 1) - 66'(s1_r) - 66'(s3_r);
  assign t_mag   = t_full[65] ? -t_full : t_full;
  assign sum_mag = sum_r[47] ? 48'(-sum_r) : 48'(sum_r);
  assign acc_sum = 49'(acc_r) + 49'(div_res.quo);

  mlc_ram #(.W(16), .DEPTH(DEPTH)) u_site (
    .clk(clk), .we(in_tvalid && in_tready), .waddr(cnt_r[ADDR_W-1:0]),
    .wdata(in_tdata), .re(rd_en), .raddr(addr), .rdata(site_rd)
  );

  mlc_ram #(.W(32), .DEPTH(DEPTH)) u_coarse (
    .clk(clk), .we(coarse_we), .waddr(addr), .wdata(avg_r),
    .re(rd_en), .raddr(addr), .rdata(coarse_rd)
  );

  mlc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dsr), .res(div_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:    if (in_tvalid && in_tready && load_last) state_nxt = S_CHK;
      S_CHK:     state_nxt = chk_bad ? S_ERR : S_CHKMUL;
      S_CHKMUL: begin
        if (side_mul > 23'(lside_r)) state_nxt = S_ERR;
        else if (k_r + 4'd1 == steps_r) state_nxt = S_CHKMOD;
      end
      S_CHKMOD:  state_nxt = S_CHKWAIT;
      S_CHKWAIT: if (div_res.done) state_nxt = (div_res.rem == '0) ? S_STEP : S_ERR;
      S_STEP:    state_nxt = S_STEP2;
      S_STEP2:   state_nxt = S_P1RD;
      S_P1RD:    state_nxt = S_P1ACC;
      S_P1ACC:   state_nxt = last_site ? S_AVGDIV : S_P1RD;
      S_AVGDIV:  state_nxt = S_AVGWAIT;
      S_AVGWAIT: if (div_res.done) state_nxt = S_SQ;
      S_SQ:      state_nxt = S_SQACC;
      S_SQACC:   state_nxt = S_P2RD;
      S_P2RD:    state_nxt = S_P2M1;
      S_P2M1:    state_nxt = S_P2M2;
      S_P2M2:    state_nxt = S_P2M3;
      S_P2M3:    state_nxt = last_site ? S_NEXTBLK : S_P2RD;
      S_NEXTBLK: begin
        if (c0_end >= 9'(lside_r) && r0_end >= 9'(lside_r)) state_nxt = S_OVLDIV;
        else state_nxt = S_P1RD;
      end
      S_OVLDIV:  state_nxt = S_OVLWAIT;
      S_OVLWAIT: if (div_res.done) state_nxt = S_OVLACC;
      S_OVLACC:  state_nxt = (k_r + 4'd1 == steps_r) ? S_DONE : S_STEP;
      S_DONE:    state_nxt = S_LOAD;
      S_ERR:     state_nxt = S_LOAD;
      default:   state_nxt = S_LOAD;
    endcase
  end

  // datapath
  always_comb begin
    cnt_nxt = cnt_r;   k_nxt = k_r;       lam_nxt = lam_r;
    area_nxt = area_r; stride_nxt = stride_r; side_nxt = side_r;
    r0_nxt = r0_r;     c0_nxt = c0_r;     i_nxt = i_r;  j_nxt = j_r;
    blk_nxt = blk_r;   row_nxt = row_r;   sum_nxt = sum_r; avg_nxt = avg_r;
    sqf_nxt = sqf_r;   s1_nxt = s1_r;     s2_nxt = s2_r; s3_nxt = s3_r;
    prod_nxt = prod_r; acc_nxt = acc_r;
    ov_nxt = ov_r;     ocplx_nxt = ocplx_r; oerr_nxt = oerr_r;
    div_start = 1'b0;  div_dvd = 48'(sum_mag); div_dsr = area_r;

    if (ov_r && out_tready) ov_nxt = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (in_tvalid && in_tready) cnt_nxt = load_last ? '0 : cnt_inc[CNT_W-1:0];
      end
      S_CHK: begin
        side_nxt = CNT_W'(1);
        k_nxt    = 4'd0;
      end
      S_CHKMUL: begin
        side_nxt = side_mul[CNT_W-1:0];
        k_nxt    = k_r + 4'd1;
      end
      S_CHKMOD: begin
        div_start = 1'b1;
        div_dvd   = 48'(lside_r);
        div_dsr   = side_r;
        k_nxt     = 4'd0;
        lam_nxt   = 8'd1;
        acc_nxt   = '0;
      end
      S_STEP: begin
        lam_nxt = lam_mul[7:0];
        r0_nxt = '0; c0_nxt = '0; i_nxt = '0; j_nxt = '0;
        blk_nxt = '0; row_nxt = '0; sum_nxt = '0;
        s1_nxt = '0; s2_nxt = '0; s3_nxt = '0;
      end
      S_STEP2: begin
        area_nxt   = area_mul[CNT_W-1:0];
        stride_nxt = stride_mul[CNT_W-1:0];
      end
      S_P1ACC, S_P2M3: begin
        if (state_r == S_P1ACC) begin
          sum_nxt = sum_r + 48'(prev);
        end else begin
          s2_nxt = s2_r + (prod_r >>> 16);
          s3_nxt = s3_r + sqf_r;
        end
        // walk the block in row order, back to its corner after the last site
        if (j_r == lam_r - 8'd1) begin
          j_nxt = '0;
          if (i_r == lam_r - 8'd1) begin
            i_nxt   = '0;
            row_nxt = blk_r;
          end else begin
            i_nxt   = i_r + 8'd1;
            row_nxt = row_r + ADDR_W'(lside_r);
          end
        end else begin
          j_nxt = j_r + 8'd1;
        end
      end
      S_AVGDIV:  div_start = 1'b1;
      S_AVGWAIT: begin
        if (div_res.done) avg_nxt = sum_r[47] ? -32'(div_res.quo) : 32'(div_res.quo);
      end
      S_SQ:    prod_nxt = avg_r * avg_r;
      S_SQACC: sqf_nxt = prod_r >>> 16;
      S_P2M1:  prod_nxt = prev * prev;
      S_P2M2: begin
        s1_nxt   = s1_r + (prod_r >>> 16);
        prod_nxt = prev * avg_r;
      end
      S_NEXTBLK: begin
        sum_nxt = '0;
        if (c0_end >= 9'(lside_r)) begin
          c0_nxt  = '0;
          r0_nxt  = r0_end[7:0];
          blk_nxt = ADDR_W'(blk_r + ADDR_W'(stride_r));
          row_nxt = ADDR_W'(blk_r + ADDR_W'(stride_r));
        end else begin
          c0_nxt  = c0_end[7:0];
          row_nxt = blk_r;
        end
      end
      S_OVLDIV: begin
        div_start = 1'b1;
        div_dvd   = 48'(t_mag >>> 21);
        div_dsr   = nn;
      end
      S_OVLACC: begin
        if (k_r >= first_r) begin
          acc_nxt = (acc_sum > 49'(CPLX_MAX)) ? CPLX_MAX : acc_sum[CPLX_W-1:0];
        end
        k_nxt = k_r + 4'd1;
      end
      S_DONE: begin
        ov_nxt = 1'b1; ocplx_nxt = acc_r; oerr_nxt = 1'b0;
      end
      S_ERR: begin
        ov_nxt = 1'b1; ocplx_nxt = '0; oerr_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // the divider keeps its quotient after done, so the overlap is summed in S_OVLACC after the wait
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      lside_r <= 8'd128;
      base_r  <= 8'd2;
      steps_r <= 4'd7;
      first_r <= 4'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LATTICE_SIDE: lside_r <= cfg_data;
          CFG_SCALE_BASE:   base_r  <= cfg_data;
          CFG_STEP_COUNT:   steps_r <= cfg_data[3:0];
          CFG_FIRST_SUMMED: first_r <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
    k_r <= k_nxt;     lam_r <= lam_nxt;   area_r <= area_nxt;
    stride_r <= stride_nxt; side_r <= side_nxt;
    r0_r <= r0_nxt;   c0_r <= c0_nxt;     i_r <= i_nxt;  j_r <= j_nxt;
    blk_r <= blk_nxt; row_r <= row_nxt;   sum_r <= sum_nxt; avg_r <= avg_nxt;
    sqf_r <= sqf_nxt; s1_r <= s1_nxt;     s2_r <= s2_nxt; s3_r <= s3_nxt;
    prod_r <= prod_nxt; acc_r <= acc_nxt;
    ocplx_r <= ocplx_nxt; oerr_r <= oerr_nxt;
  end

  assign out_tvalid   = ov_r;
  assign out_tdata    = ocplx_r;
  assign out_tuser[0] = oerr_r;

`ifndef SYNTHESIS
  a_ready_only_loading: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_LOAD) else $error("input ready outside load");
  a_counter_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_LOAD |-> cnt_r == '0) else $error("frame counter running in compute");
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0) else $error("error result not zero");
  a_frame_end_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK |-> !ov_r) else $error("compute started with result pending");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_multiscale_lattice_complexity.sv @@
// ----------------------------------------------------------------------------
// tb_multiscale_lattice_complexity
// self-checking bench: streams spin lattices into the block, predicts the
// summed overlap of every frame and compares it with each out_* request
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multiscale_lattice_complexity;
  timeunit 1ns;
  timeprecision 1ps;

  import mlc_pkg::*;

  localparam longint unsigned CPLX_SAT = 64'hFF_FFFF_FFFF;
  localparam int RAND_SAMPLES = 1350;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [CPLX_W-1:0] cplx;
    logic              err;
  } frame_result_t;

  class cplx_scoreboard;
    int unsigned side = 128, base = 2, steps = 7, first = 0;
    shortint sites[DEPTH];
    int coarse[DEPTH];
    int unsigned fill = 0;
    frame_result_t expected_q[$];
    int fails = 0, frames = 0, err_frames = 0, samples = 0;

    function void set_reg(logic [1:0] idx, logic [7:0] v);
      case (idx)
        CFG_LATTICE_SIDE: side = v;
        CFG_SCALE_BASE:   base = v;
        CFG_STEP_COUNT:   steps = v[3:0];
        CFG_FIRST_SUMMED: first = v[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned frame_len();
      return (side == 0 || side > MAX_SIDE) ? DEPTH : side * side;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit usable();
      int unsigned blk;
      blk = 1;
      if (side == 0 || side > MAX_SIDE || base < 2) return 0;
      if (steps == 0 || steps > MAX_STEPS) return 0;
      for (int k = 0; k < steps; k++) begin
        blk *= base;
        if (blk > side) return 0;
      end
      return (side % blk) == 0;
    endfunction

    function longint field_at(int unsigned step, int unsigned idx);
      return (step == 0) ? longint'(sites[idx]) * 65536 : longint'(coarse[idx]);
    endfunction

    // one coarse-graining pass; returns the signed overlap, 24 fraction bits
    function longint coarse_overlap(int unsigned step, int unsigned lam);
      longint s1, s2, s3, area, acc, avg, a, dsr;
      int unsigned nb, idx;
      s1 = 0; s2 = 0; s3 = 0;
      area = longint'(lam) * lam;
      nb = side / lam;
      for (int unsigned bi = 0; bi < nb; bi++)
        for (int unsigned bj = 0; bj < nb; bj++) begin
          acc = 0;
          for (int unsigned i = 0; i < lam; i++)
            for (int unsigned j = 0; j < lam; j++)
              acc += field_at(step, (bi * lam + i) * side + bj * lam + j);
          avg = acc / area;
          for (int unsigned i = 0; i < lam; i++)
            for (int unsigned j = 0; j < lam; j++) begin
              idx = (bi * lam + i) * side + bj * lam + j;
              a = field_at(step, idx);
              s1 += (a * a) >>> 16;
              s2 += (a * avg) >>> 16;
              s3 += (avg * avg) >>> 16;
              coarse[idx] = int'(avg);
            end
        end
      // signed divisor keeps the division signed
      dsr = longint'(2) * longint'(side) * longint'(side) * 1048576;
      return (2 * s2 - s1 - s3) / dsr;
    endfunction

    function void note_sample(logic [15:0] v);
      frame_result_t r;
      longint ovl[MAX_STEPS];
      longint unsigned total, mag;
      int unsigned lam;
      samples++;
      sites[fill % DEPTH] = v;
      fill++;
      if (fill < frame_len()) return;
      fill = 0;
      frames++;
      r.cplx = '0;
      r.err = 1'b0;
      if (!usable()) begin
        r.err = 1'b1;
        err_frames++;
      end else begin
        lam = 1;
        for (int k = 0; k < steps; k++) begin
          lam *= base;
          ovl[k] = coarse_overlap(k, lam);
        end
        total = 0;
        for (int k = first; k < steps; k++) begin
          mag = (ovl[k] < 0) ? longint'(-ovl[k]) : longint'(ovl[k]);
          total += mag;
          if (total > CPLX_SAT) total = CPLX_SAT;
        end
        r.cplx = total[CPLX_W-1:0];
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [CPLX_W-1:0] cplx, logic err);
      frame_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result complexity=%0d error=%0b", $realtime, cplx, err);
        fails++;
        return;
      end
      e = expected_q.pop_front();
      if (cplx !== e.cplx) begin
        $display("%0t: complexity expected %0d actual %0d", $realtime, e.cplx, cplx);
        fails++;
      end
      if (err !== e.err) begin
        $display("%0t: config_error expected %0b actual %0b", $realtime, e.err, err);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] spin_value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [39:0] complexity
  logic [0:0]  out_tuser;       // [0] config_error
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_LATTICE_SIDE;
  logic [7:0]  cfg_data = '0;

  cplx_scoreboard sb = new();
  int send_idle_pct = 17;
  int recv_idle_pct = 72;
  int hold_left = 0;
  longint cycles = 0;

  multiscale_lattice_complexity dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0]);

  // receiver: long hold-off counted here, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_sample(input logic [15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = v;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(v);
    @(negedge clk);
  endtask

  // kind 0: full range, 1: extremes and special values, 2: +-1.0 spins
  task automatic send_frame(input int kind);
    logic [15:0] corner[7] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000,
                               16'hC000, 16'h0001, 16'hFFFF};
    int unsigned len;
    logic [15:0] v;
    len = sb.frame_len();
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        1: v = corner[i % 7];
        2: v = $urandom_range(1) ? 16'h4000 : 16'hC000;
        default: v = 16'($urandom());
      endcase
      send_sample(v);
    end
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input int n, input int b, input int st, input int fs);
    drain();
    write_reg(CFG_LATTICE_SIDE, 8'(n));
    write_reg(CFG_SCALE_BASE, 8'(b));
    write_reg(CFG_STEP_COUNT, 8'(st));
    write_reg(CFG_FIRST_SUMMED, 8'(fs));
  endtask

  initial begin
    int rand_sent;
    int n, b, st, m, blk, nframes;
    bit held;
    rand_sent = 0;
    held = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part
    configure(1, 2, 1, 0);     send_frame(1);   // single site, block side too big
    configure(4, 2, 2, 0);     send_frame(1);
    configure(4, 4, 1, 1);     send_frame(0);   // empty sum
    configure(8, 2, 3, 9);     send_frame(2);
    configure(8, 2, 3, 0);     send_frame(1);
    configure(8, 2, 10, 0);    send_frame(0);   // block side overflow
    configure(4, 2, 0, 0);     send_frame(0);   // no steps
    configure(4, 2, 15, 0);    send_frame(0);
    configure(4, 0, 1, 0);     send_frame(0);   // base below two
    configure(4, 1, 1, 0);     send_frame(0);
    configure(6, 4, 1, 0);     send_frame(0);   // side not a multiple
    configure(9, 3, 2, 1);     send_frame(1);

    // receiver held off over two frames, last request of the second one stalls
    configure(4, 2, 2, 0);     send_frame(0);
    @(posedge clk);
    hold_left = 2000;
    @(negedge clk);
    send_frame(2);

    // random part
    while (rand_sent < RAND_SAMPLES) begin
      if (rand_sent < RAND_SAMPLES / 3) begin
        send_idle_pct = 17; recv_idle_pct = 72;
      end else if (rand_sent < 2 * RAND_SAMPLES / 3) begin
        send_idle_pct = 72; recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if ($urandom_range(7) == 0) begin
        configure($urandom_range(1, 10), $urandom_range(0, 5),
                  $urandom_range(0, 15), $urandom_range(0, 15));
      end else begin
        do begin
          b = $urandom_range(2, 4);
          st = $urandom_range(1, 3);
          blk = 1;
          for (int k = 0; k < st; k++) blk *= b;
          m = $urandom_range(1, 3);
          n = blk * m;
        end while (n > 24);
        configure(n, b, st, $urandom_range(0, st));
      end
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        // back-to-back frame against a long receiver hold-off
        if (!held && f == 1) begin
          @(posedge clk);
          hold_left = 600;
          @(negedge clk);
          held = 1;
        end
        rand_sent += sb.frame_len();
        send_frame($urandom_range(3) == 0 ? 2 : 0);
      end
    end
    drain();

    $display("%0d samples in %0d frames checked, %0d with unusable settings",
             sb.samples, sb.frames, sb.err_frames);
    if (sb.fails == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", sb.fails);
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ multiscale_lattice_complexity.f @@
design/mlc_pkg.sv
design/mlc_ram.sv
design/mlc_div.sv
design/multiscale_lattice_complexity.sv
tb/sv/tb_multiscale_lattice_complexity.sv
